// ----- hw/rtl/tli_pkg.sv -----
// tli_pkg: shared types and constants of the table linear interpolator
// holds field widths, action and status codes, and controller/datapath structs
// no dependencies
package tli_pkg;

  localparam int ACTION_W  = 2;
  localparam int WEAPON_W  = 3;
  localparam int KEY_W     = 12;
  localparam int VALUE_W   = 20;
  localparam int DIST_W    = 16;
  localparam int FRAC_W    = 4;
  localparam int ENTRY_W   = KEY_W + VALUE_W;
  localparam int STATUS_W  = 2;
  localparam int PROD_W    = DIST_W + VALUE_W;
  localparam int DIVCNT_W  = $clog2(PROD_W);

  localparam int S_TDATA_W = KEY_W + VALUE_W + DIST_W;
  localparam int S_TUSER_W = ACTION_W + WEAPON_W;
  localparam int M_TDATA_W = ((VALUE_W + 7) / 8) * 8;
  localparam int M_TUSER_W = STATUS_W;

  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_FOUND   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ACCEPT  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_REJECT  = 2'd3;

  localparam logic [1:0] RD_LAST = 2'd0;
  localparam logic [1:0] RD_MID  = 2'd1;
  localparam logic [1:0] RD_A    = 2'd2;
  localparam logic [1:0] RD_B    = 2'd3;

  localparam logic [1:0] RES_ZERO   = 2'd0;
  localparam logic [1:0] RES_RDV    = 2'd1;
  localparam logic [1:0] RES_INTERP = 2'd2;

  typedef struct packed {
    logic       load;
    logic       clr;
    logic       wr;
    logic [1:0] rd_sel;
    logic       srch_init;
    logic       srch_upd;
    logic       lat_a;
    logic       setup;
    logic       mul;
    logic       div_step;
    logic       res_load;
    logic [1:0] res_src;
    logic [STATUS_W-1:0] res_st;
    logic       out_load;
  } tli_cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic w_ok;
    logic val_nz;
    logic cnt_zero;
    logic cnt_full;
    logic cnt_lt2;
    logic key_gt;
    logic len_zero;
    logic pos_zero;
    logic pos_last;
    logic a_exact;
    logic div_done;
    logic out_free;
  } tli_stat_t;

endpackage

// ----- hw/rtl/tli_ctrl.sv -----
// tli_ctrl: controller state machine of the table linear interpolator
// sequences clear, append and query through the datapath; uses tli_pkg
module tli_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  tli_pkg::tli_stat_t stat,
  output tli_pkg::tli_cmd_t  cmd
);
  import tli_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_APPCHK = 4'd2;
  localparam logic [3:0] S_SRCH   = 4'd3;
  localparam logic [3:0] S_SCMP   = 4'd4;
  localparam logic [3:0] S_FETCHA = 4'd5;
  localparam logic [3:0] S_FETCHB = 4'd6;
  localparam logic [3:0] S_SETUP  = 4'd7;
  localparam logic [3:0] S_MUL    = 4'd8;
  localparam logic [3:0] S_DIV    = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [3:0] state, state_next;

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.res_load = 1'b1;
        cmd.res_src  = RES_ZERO;
        cmd.res_st   = ST_MISSING;
        state_next   = S_DONE;
        case (stat.action)
          ACT_CLEAR: begin
            cmd.clr    = stat.w_ok;
            cmd.res_st = stat.w_ok ? ST_ACCEPT : ST_REJECT;
          end
          ACT_APPEND: begin
            cmd.res_st = ST_REJECT;
            if (stat.w_ok && stat.val_nz && !stat.cnt_full) begin
              if (stat.cnt_zero) begin
                cmd.wr     = 1'b1;
                cmd.res_st = ST_ACCEPT;
              end else begin
                cmd.res_load = 1'b0;
                cmd.rd_sel   = RD_LAST;
                state_next   = S_APPCHK;
              end
            end
          end
          ACT_QUERY: begin
            if (stat.w_ok && !stat.cnt_lt2) begin
              cmd.res_load  = 1'b0;
              cmd.srch_init = 1'b1;
              state_next    = S_SRCH;
            end
          end
          default: begin
            cmd.res_st = ST_MISSING;
          end
        endcase
      end
      S_APPCHK: begin
        cmd.res_load = 1'b1;
        cmd.res_src  = RES_ZERO;
        cmd.wr       = stat.key_gt;
        cmd.res_st   = stat.key_gt ? ST_ACCEPT : ST_REJECT;
        state_next   = S_DONE;
      end
      S_SRCH: begin
        cmd.rd_sel = RD_MID;
        state_next = stat.len_zero ? S_FETCHA : S_SCMP;
      end
      S_SCMP: begin
        cmd.srch_upd = 1'b1;
        state_next   = S_SRCH;
      end
      S_FETCHA: begin
        cmd.rd_sel = RD_A;
        if (stat.pos_zero) begin
          cmd.res_load = 1'b1;
          cmd.res_src  = RES_ZERO;
          cmd.res_st   = ST_MISSING;
          state_next   = S_DONE;
        end else begin
          state_next = S_FETCHB;
        end
      end
      S_FETCHB: begin
        cmd.lat_a  = 1'b1;
        cmd.rd_sel = RD_B;
        if (stat.a_exact) begin
          cmd.res_load = 1'b1;
          cmd.res_src  = RES_RDV;
          cmd.res_st   = ST_FOUND;
          state_next   = S_DONE;
        end else if (stat.pos_last) begin
          cmd.res_load = 1'b1;
          cmd.res_src  = RES_ZERO;
          cmd.res_st   = ST_MISSING;
          state_next   = S_DONE;
        end else begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.res_load = 1'b1;
        cmd.res_src  = RES_INTERP;
        cmd.res_st   = ST_FOUND;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/tli_dpath.sv -----
// tli_dpath: datapath of the table linear interpolator
// point memory, point counts, search registers, multiplier, serial divider, output
// register; uses tli_pkg
module tli_dpath #(
  parameter int WEAPONS = 6,
  parameter int ENTRIES = 512
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [tli_pkg::S_TDATA_W-1:0]    s_tdata,
  input  logic [tli_pkg::S_TUSER_W-1:0]    s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [tli_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic [tli_pkg::M_TUSER_W-1:0]    m_tuser,
  input  tli_pkg::tli_cmd_t                cmd,
  output tli_pkg::tli_stat_t               stat
);
  import tli_pkg::*;

  localparam int DEPTH = WEAPONS * ENTRIES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(ENTRIES + 1);
  localparam int WSW   = (WEAPONS > 1) ? $clog2(WEAPONS) : 1;

  logic [ACTION_W-1:0] action;
  logic [WEAPON_W-1:0] weapon;
  logic [KEY_W-1:0]    point_key;
  logic [VALUE_W-1:0]  point_value;
  logic [DIST_W-1:0]   query_dist;
  logic [AW-1:0]       base;

  logic [CW-1:0]       counts [WEAPONS];
  logic [ENTRY_W-1:0]  mem [DEPTH];
  logic [ENTRY_W-1:0]  rdata;

  logic [CW-1:0]       lo, len;
  logic [KEY_W-1:0]    ka;
  logic [VALUE_W-1:0]  va;
  logic [DIST_W-1:0]   off, den;
  logic [VALUE_W-1:0]  dmag;
  logic                dneg;
  logic [PROD_W-1:0]   quot;
  logic [DIST_W-1:0]   rem;
  logic [DIVCNT_W-1:0] dcnt;

  logic [VALUE_W-1:0]  res_val;
  logic [STATUS_W-1:0] res_st;
  logic [VALUE_W-1:0]  out_val;
  logic [STATUS_W-1:0] out_st;

  logic                w_ok;
  logic [WSW-1:0]      widx;
  logic [CW-1:0]       cnt, half, mid, idx;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic [KEY_W-1:0]    rd_key;
  logic [VALUE_W-1:0]  rd_val;
  logic [DIST_W-1:0]   rd_key16;
  logic [PROD_W-1:0]   prod;
  logic [DIST_W:0]     trial;
  logic                trial_ge;
  logic [VALUE_W-1:0]  interp;
  logic [VALUE_W-1:0]  res_mux;

  assign w_ok     = ({1'b0, weapon} < (WEAPON_W + 1)'(WEAPONS));
  assign widx     = WSW'(weapon);
  assign cnt      = w_ok ? counts[widx] : '0;
  assign half     = len >> 1;
  assign mid      = lo + half;
  assign rd_key   = rdata[ENTRY_W-1:VALUE_W];
  assign rd_val   = rdata[VALUE_W-1:0];
  assign rd_key16 = {rd_key, {FRAC_W{1'b0}}};

  always_comb begin
    case (cmd.rd_sel)
      RD_LAST: idx = cnt - CW'(1);
      RD_MID:  idx = mid;
      RD_A:    idx = lo - CW'(1);
      RD_B:    idx = lo;
      default: idx = lo;
    endcase
  end

  assign rd_addr = base + AW'(idx);
  assign wr_addr = base + AW'(cnt);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action      <= s_tuser[ACTION_W-1:0];
      weapon      <= s_tuser[ACTION_W +: WEAPON_W];
      point_key   <= s_tdata[KEY_W-1:0];
      point_value <= s_tdata[KEY_W +: VALUE_W];
      query_dist  <= s_tdata[KEY_W + VALUE_W +: DIST_W];
      base        <= AW'(32'(s_tuser[ACTION_W +: WEAPON_W]) * ENTRIES);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WEAPONS; i++) begin
        counts[i] <= '0;
      end
    end else if (cmd.clr) begin
      counts[widx] <= '0;
    end else if (cmd.wr) begin
      counts[widx] <= cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wr_addr] <= {point_key, point_value};
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.srch_init) begin
      lo  <= '0;
      len <= cnt;
    end else if (cmd.srch_upd) begin
      if (rd_key16 <= query_dist) begin
        lo  <= mid + CW'(1);
        len <= len - half - CW'(1);
      end else begin
        len <= half;
      end
    end
  end

  assign prod     = off * dmag;
  assign trial    = {rem, quot[PROD_W-1]};
  assign trial_ge = (trial >= {1'b0, den});
  assign interp   = dneg ? (va - quot[VALUE_W-1:0]) : (va + quot[VALUE_W-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.lat_a) begin
      ka <= rd_key;
      va <= rd_val;
    end
    if (cmd.setup) begin
      off  <= query_dist - {ka, {FRAC_W{1'b0}}};
      den  <= {rd_key - ka, {FRAC_W{1'b0}}};
      dneg <= (rd_val < va);
      dmag <= (rd_val < va) ? (va - rd_val) : (rd_val - va);
    end
    if (cmd.mul) begin
      quot <= prod;
      rem  <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      rem  <= trial_ge ? DIST_W'(trial - {1'b0, den}) : DIST_W'(trial);
      quot <= {quot[PROD_W-2:0], trial_ge};
      dcnt <= dcnt + DIVCNT_W'(1);
    end
  end

  always_comb begin
    case (cmd.res_src)
      RES_RDV:    res_mux = rd_val;
      RES_INTERP: res_mux = interp;
      default:    res_mux = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_val <= res_mux;
      res_st  <= cmd.res_st;
    end
    if (cmd.out_load) begin
      out_val <= res_val;
      out_st  <= res_st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = M_TDATA_W'(out_val);
  assign m_tuser = out_st;

  assign stat.action   = action;
  assign stat.w_ok     = w_ok;
  assign stat.val_nz   = (point_value != '0);
  assign stat.cnt_zero = (cnt == '0);
  assign stat.cnt_full = (cnt >= CW'(ENTRIES));
  assign stat.cnt_lt2  = (cnt < CW'(2));
  assign stat.key_gt   = (point_key > rd_key);
  assign stat.len_zero = (len == '0);
  assign stat.pos_zero = (lo == '0);
  assign stat.pos_last = (lo == cnt);
  assign stat.a_exact  = (rd_key16 == query_dist);
  assign stat.div_done = (dcnt == DIVCNT_W'(PROD_W - 1));
  assign stat.out_free = !m_tvalid || m_tready;

endmodule

// ----- hw/rtl/table_linear_interpolator_unit.sv -----
// table_linear_interpolator_unit: piecewise linear lookup over per-curve breakpoint tables
// a query runs a binary search over the table's points, each step a read state and a
// compare state on the point memory read port, then a multiply and a bit-serial divide;
// one item is worked on at a time
// reset clears the point counts of all tables; the point memory is not initialized
module table_linear_interpolator_unit #(
  parameter int WEAPONS = 6,
  parameter int ENTRIES = 512
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // point_key, point_value, query_distance
  input  logic [tli_pkg::S_TDATA_W-1:0] s_tdata,
  // action, weapon
  input  logic [tli_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // result_value, zero pad
  output logic [tli_pkg::M_TDATA_W-1:0] m_tdata,
  // status
  output logic [tli_pkg::M_TUSER_W-1:0] m_tuser
);
  import tli_pkg::*;

  tli_cmd_t  cmd;
  tli_stat_t stat;

  tli_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tli_dpath #(
    .WEAPONS (WEAPONS),
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

// ----- verif/table_linear_interpolator_unit_tb.sv -----
// table_linear_interpolator_unit_tb: self-checking bench for the breakpoint table lookup unit
// drives clear, append and query beats and predicts every result in a scoreboard class
// depends on tli_pkg and table_linear_interpolator_unit
`timescale 1ns / 100ps

module table_linear_interpolator_unit_tb;
  import tli_pkg::*;

  localparam int CURVES      = 6;
  localparam int ENTRY_MAX   = 512;
  localparam int HOLD_CYCLES = 400;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    bit [VALUE_W-1:0]  value;
    bit [STATUS_W-1:0] status;
  } lookup_reply_t;

  class curve_lookup_checker;
    bit [KEY_W-1:0]   pt_key [CURVES][ENTRY_MAX];
    bit [VALUE_W-1:0] pt_val [CURVES][ENTRY_MAX];
    int               pt_cnt [CURVES];
    lookup_reply_t    pending_replies [$];
    int n_items, n_found, n_missing, n_accept, n_reject, n_fail;

    function bit find_value(int w, bit [DIST_W-1:0] d, output bit [VALUE_W-1:0] v);
      longint ka, kb, va, vb, q;
      v = '0;
      for (int i = 0; i + 1 < pt_cnt[w]; i++) begin
        ka = 16 * longint'(pt_key[w][i]);
        kb = 16 * longint'(pt_key[w][i+1]);
        va = longint'(pt_val[w][i]);
        vb = longint'(pt_val[w][i+1]);
        if (ka < d && kb > d) begin
          q = va + ((longint'(d) - ka) * (vb - va)) / (kb - ka);
          v = q[VALUE_W-1:0];
          return 1'b1;
        end
        if (ka == d) begin
          v = va[VALUE_W-1:0];
          return 1'b1;
        end
        if (kb == d) begin
          v = vb[VALUE_W-1:0];
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void log_request(bit [ACTION_W-1:0] act, bit [WEAPON_W-1:0] w,
                              bit [KEY_W-1:0] key, bit [VALUE_W-1:0] val,
                              bit [DIST_W-1:0] query_dist);
      lookup_reply_t r;
      int wi;
      wi = int'(w);
      r.value = '0;
      r.status = ST_MISSING;
      n_items++;
      case (act)
        ACT_CLEAR: begin
          if (wi < CURVES) begin
            pt_cnt[wi] = 0;
            r.status = ST_ACCEPT;
          end else begin
            r.status = ST_REJECT;
          end
        end
        ACT_APPEND: begin
          r.status = ST_REJECT;
          if (wi < CURVES && val != 0 && pt_cnt[wi] < ENTRY_MAX) begin
            if (pt_cnt[wi] == 0 || key > pt_key[wi][pt_cnt[wi]-1]) begin
              pt_key[wi][pt_cnt[wi]] = key;
              pt_val[wi][pt_cnt[wi]] = val;
              pt_cnt[wi]++;
              r.status = ST_ACCEPT;
            end
          end
        end
        ACT_QUERY: begin
          if (wi < CURVES && find_value(wi, query_dist, r.value)) r.status = ST_FOUND;
          else r.value = '0;
        end
        default: ;
      endcase
      case (r.status)
        ST_FOUND:   n_found++;
        ST_MISSING: n_missing++;
        ST_ACCEPT:  n_accept++;
        default:    n_reject++;
      endcase
      pending_replies.push_back(r);
    endfunction

    function void check_reply(logic [M_TDATA_W-1:0] data, logic [M_TUSER_W-1:0] user);
      lookup_reply_t r;
      if (pending_replies.size() == 0) begin
        $error("result beat with nothing expected: result_value %0h status %0d",
               data[VALUE_W-1:0], user);
        n_fail++;
        return;
      end
      r = pending_replies.pop_front();
      if (data[VALUE_W-1:0] !== r.value) begin
        $error("result_value expected %0h got %0h", r.value, data[VALUE_W-1:0]);
        n_fail++;
      end
      if (user !== r.status) begin
        $error("status expected %0d got %0d", r.status, user);
        n_fail++;
      end
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [S_TUSER_W-1:0] s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;

  curve_lookup_checker sb;
  int   snd_idle_pct;
  int   rcv_idle_pct;
  logic hold_tog;
  logic hold_seen;
  int   hold_left;

  table_linear_interpolator_unit #(
    .WEAPONS(CURVES),
    .ENTRIES(ENTRY_MAX)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_seen <= hold_tog;
      hold_left <= 0;
    end else if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_reply(m_tdata, m_tuser);
  end

  task automatic send_item(input int act, input int w, input int key, input int val,
                           input int query_dist);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {DIST_W'(query_dist), VALUE_W'(val), KEY_W'(key)};
    s_tuser  <= {WEAPON_W'(w), ACTION_W'(act)};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.log_request(ACTION_W'(act), WEAPON_W'(w), KEY_W'(key), VALUE_W'(val),
                   DIST_W'(query_dist));
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 7) == 0) return '1;
    return VALUE_W'($urandom_range(1, (1 << VALUE_W) - 1));
  endfunction

  task automatic build_curve(input int w, input int n);
    int k;
    int step_max;
    send_item(ACT_CLEAR, w, $urandom_range(0, 4095), $urandom_range(0, 1048575),
              $urandom_range(0, 65535));
    k = $urandom_range(0, 1000);
    step_max = $urandom_range(1, 200);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        if ($urandom_range(0, 1) == 1) send_item(ACT_APPEND, w, k, '0, $urandom_range(0, 65535));
        else send_item(ACT_APPEND, w, $urandom_range(0, k), pick_value(),
                       $urandom_range(0, 65535));
      end else begin
        send_item(ACT_APPEND, w, k, pick_value(), $urandom_range(0, 65535));
        k += $urandom_range(1, step_max);
      end
    end
  endtask

  task automatic probe_curve(input int w, input int n);
    int c;
    int lo;
    int hi;
    int d;
    int pick;
    for (int i = 0; i < n; i++) begin
      c = sb.pt_cnt[w];
      pick = $urandom_range(0, 9);
      if (c > 0) begin
        lo = 16 * int'(sb.pt_key[w][0]);
        hi = 16 * int'(sb.pt_key[w][c-1]);
      end
      if (c == 0 || pick >= 8) d = $urandom_range(0, 65535);
      else if (pick < 5) d = $urandom_range(lo, hi);
      else if (pick < 7) d = 16 * int'(sb.pt_key[w][$urandom_range(0, c - 1)]);
      else if ($urandom_range(0, 1) == 1) d = hi + 1;
      else d = (lo > 0) ? lo - 1 : 0;
      send_item(ACT_QUERY, w, $urandom_range(0, 4095), $urandom_range(0, 1048575), d);
    end
  endtask

  task automatic fill_curve(input int w);
    int k;
    send_item(ACT_CLEAR, w, 0, 0, 0);
    k = 0;
    while (sb.pt_cnt[w] < ENTRY_MAX) begin
      send_item(ACT_APPEND, w, k, pick_value(), $urandom_range(0, 65535));
      k += $urandom_range(1, 7);
    end
    repeat (3) send_item(ACT_APPEND, w, 4095, pick_value(), 0);
    probe_curve(w, 30);
  endtask

  task automatic run_mix(input int item_goal);
    int pick;
    int w;
    while (sb.n_items < item_goal) begin
      pick = $urandom_range(0, 19);
      w = $urandom_range(0, CURVES - 1);
      if (pick < 13) begin
        build_curve(w, $urandom_range(0, 12));
        probe_curve(w, $urandom_range(2, 10));
      end else if (pick < 16) begin
        probe_curve(w, $urandom_range(1, 6));
      end else if (pick < 18) begin
        send_item($urandom_range(0, 3), $urandom_range(0, 7), $urandom_range(0, 4095),
                  $urandom_range(0, 1048575), $urandom_range(0, 65535));
      end else if (pick < 19) begin
        send_item($urandom_range(0, 3), $urandom_range(CURVES, 7), $urandom_range(0, 4095),
                  $urandom_range(0, 1048575), $urandom_range(0, 65535));
      end else begin
        wait_drain();
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    hold_tog = 1'b0;
    snd_idle_pct = 20;
    rcv_idle_pct = 54;
    sb = new;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, short tables, bad appends, bad selectors
    send_item(ACT_QUERY, 0, 0, 0, 0);
    send_item(ACT_CLEAR, 0, 0, 0, 0);
    send_item(ACT_APPEND, 0, 0, 1, 0);
    send_item(ACT_QUERY, 0, 0, 0, 0);
    send_item(ACT_APPEND, 0, 0, 5, 0);
    send_item(ACT_APPEND, 0, 10, 0, 0);
    send_item(ACT_APPEND, 0, 4095, '1, '1);
    send_item(ACT_QUERY, 0, '1, '1, 0);
    send_item(ACT_QUERY, 0, 0, 0, 65520);
    send_item(ACT_QUERY, 0, 0, 0, 65535);
    send_item(ACT_QUERY, 0, 0, 0, 1);
    send_item(ACT_QUERY, 0, 0, 0, 65519);
    send_item(ACT_CLEAR, 1, 0, 0, 0);
    send_item(ACT_APPEND, 1, 100, '1, 0);
    send_item(ACT_APPEND, 1, 103, 3, 0);
    send_item(ACT_APPEND, 1, 50, 7, 0);
    send_item(ACT_QUERY, 1, 0, 0, 1599);
    send_item(ACT_QUERY, 1, 0, 0, 1601);
    send_item(ACT_QUERY, 1, 0, 0, 1648);
    send_item(ACT_CLEAR, 6, 0, 0, 0);
    send_item(ACT_APPEND, 7, 1, 1, 0);
    send_item(ACT_QUERY, 6, 0, 0, 0);
    send_item(ACT_UNUSED, 0, '1, '1, '1);
    send_item(ACT_CLEAR, 0, 0, 0, 0);
    send_item(ACT_QUERY, 0, 0, 0, 0);
    wait_drain();

    hold_tog <= ~hold_tog;
    build_curve(2, 12);
    probe_curve(2, 10);
    run_mix(330);
    wait_drain();

    snd_idle_pct = 54;
    rcv_idle_pct = 20;
    run_mix(650);
    wait_drain();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    fill_curve($urandom_range(0, CURVES - 1));
    run_mix(1200);
    wait_drain();
    repeat (100) @(posedge clk);

    if (sb.pending() != 0) begin
      $error("%0d results never arrived", sb.pending());
      sb.n_fail += sb.pending();
    end
    $display("%0d beats: %0d values found, %0d not found, %0d loads/clears taken, %0d refused",
             sb.n_items, sb.n_found, sb.n_missing, sb.n_accept, sb.n_reject);
    $display("one table filled to capacity, output held off %0d cycles, three idle mixes",
             HOLD_CYCLES);
    if (sb.n_fail == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
